### src/ssq_pkg.sv
// Shared constants for the sound script sequencer: field widths, request codes,
// script layout offsets and parameter defaults. No dependencies.
package ssq_pkg;

    // Field widths of the request and response words
    localparam int REQ_TYPE_W   = 2;
    localparam int CODE_W       = 8;
    localparam int LOAD_ADDR_W  = 10;
    localparam int BYTE_W       = 8;
    localparam int REG_INDEX_W  = 3;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_TRIGGER = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_TICK    = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_LOAD    = 2'd2;

    // Script layout: map row at the base, entries at a fixed offset from it
    localparam int MAP_BASE   = 16'h70C1;
    localparam int ENTRY_BASE = 16'h719B;
    localparam int ENTRY_OFS  = ENTRY_BASE - MAP_BASE;

    // Byte offsets inside one 4-byte script entry
    localparam logic [1:0] ENT_VALUE = 2'd0;
    localparam logic [1:0] ENT_TICKS = 2'd1;
    localparam logic [1:0] ENT_DELTA = 2'd2;
    localparam logic [1:0] ENT_STEPS = 2'd3;

    localparam logic [BYTE_W-1:0] HI_NIBBLE  = 8'hF0;
    localparam logic [BYTE_W-1:0] LO_NIBBLE  = 8'h0F;
    localparam logic [BYTE_W-1:0] COUNT_SEED = 8'h01;

    // Parameter defaults
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int SCRIPT_DEPTH_DEF = 1024;
    localparam int MAX_FETCH_DEF    = 8;

endpackage

### src/ssq_in_if.sv
// Request channel of the sound script sequencer: valid/ready plus request word.
// Depends on ssq_pkg for field widths.
interface ssq_in_if;
    import ssq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [REQ_TYPE_W-1:0]  req_type;
    logic [CODE_W-1:0]      sound_code;
    logic                   play_allowed;
    logic [LOAD_ADDR_W-1:0] load_address;
    logic [BYTE_W-1:0]      load_data;

    modport source (
        output valid, req_type, sound_code, play_allowed, load_address, load_data,
        input  ready
    );

    modport sink (
        input  valid, req_type, sound_code, play_allowed, load_address, load_data,
        output ready
    );

endinterface

### src/ssq_out_if.sv
// Response channel of the sound script sequencer: valid/ready plus register write word.
// Depends on ssq_pkg for field widths.
interface ssq_out_if;
    import ssq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   chip_select;
    logic [REG_INDEX_W-1:0] register_index;
    logic [BYTE_W-1:0]      register_value;
    logic                   last_write;

    modport source (
        output valid, chip_select, register_index, register_value, last_write,
        input  ready
    );

    modport sink (
        input  valid, chip_select, register_index, register_value, last_write,
        output ready
    );

endinterface

### src/sound_script_sequencer.sv
// Sixteen-channel sound script player: script memory, per-channel counters and
// a small sequencer around one memory read port. Depends on ssq_pkg, ssq_in_if, ssq_out_if.
//
//  channel | dir | word                                                      | handshake
//  --------+-----+-----------------------------------------------------------+-----------
//  req     | in  | req_type, sound_code, play_allowed, load_address, load_data | valid/ready
//  rsp     | out | chip_select, register_index, register_value, last_write   | valid/ready
//
// A load is written from idle; a trigger does a map read and write-back per channel; a tick
// checks each channel and steps it (delta, tick reload) or fetches entries (advance, value,
// steps, ticks), emits it if updated, then flushes. The one registered read port sets this.
// Reset clears all channel state at once; the script memory has no reset.
// req.ready is high only while idle; rsp back-pressure stalls the sequencer only when
// both the held word and the output register are full.
module sound_script_sequencer #(
    parameter int NUM_CHANNELS = ssq_pkg::NUM_CHANNELS_DEF,
    parameter int SCRIPT_DEPTH = ssq_pkg::SCRIPT_DEPTH_DEF,
    parameter int MAX_FETCH    = ssq_pkg::MAX_FETCH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ssq_in_if.sink    req,
    ssq_out_if.source rsp
);
    import ssq_pkg::*;

    localparam int CH_W   = $clog2(NUM_CHANNELS);
    localparam int ADDR_W = $clog2(SCRIPT_DEPTH);
    localparam int FCNT_W = $clog2(MAX_FETCH + 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_TRIG_RD   = 4'd1;
    localparam logic [3:0] ST_TRIG_WB   = 4'd2;
    localparam logic [3:0] ST_TICK_CHK  = 4'd3;
    localparam logic [3:0] ST_STEP_DLT  = 4'd4;
    localparam logic [3:0] ST_STEP_TCK  = 4'd5;
    localparam logic [3:0] ST_FETCH_A0  = 4'd6;
    localparam logic [3:0] ST_FETCH_VAL = 4'd7;
    localparam logic [3:0] ST_FETCH_STP = 4'd8;
    localparam logic [3:0] ST_FETCH_END = 4'd9;
    localparam logic [3:0] ST_EMIT      = 4'd10;
    localparam logic [3:0] ST_FLUSH     = 4'd11;

    // Byte address of one entry byte for a script pointer
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [BYTE_W-1:0] p,
                                                     input logic [1:0] k);
        return ADDR_W'(ENTRY_OFS) + ADDR_W'({p, 1'b0}) + ADDR_W'(k);
    endfunction

    // Script memory
    logic [BYTE_W-1:0] script_mem [SCRIPT_DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data_reg;

    // Per-channel state
    logic [BYTE_W-1:0] chan_ptr_reg   [NUM_CHANNELS];
    logic [BYTE_W-1:0] chan_ptr_next  [NUM_CHANNELS];
    logic [BYTE_W-1:0] chan_val_reg   [NUM_CHANNELS];
    logic [BYTE_W-1:0] chan_val_next  [NUM_CHANNELS];
    logic [BYTE_W-1:0] chan_step_reg  [NUM_CHANNELS];
    logic [BYTE_W-1:0] chan_step_next [NUM_CHANNELS];
    logic [BYTE_W-1:0] chan_tick_reg  [NUM_CHANNELS];
    logic [BYTE_W-1:0] chan_tick_next [NUM_CHANNELS];

    // Sequencer
    logic [3:0]        state_reg, state_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [CODE_W-1:0] row_reg, row_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;

    // Held result word: last_write is only known once the scan moves past it
    logic                   pend_valid_reg, pend_valid_next;
    logic                   pend_chip_reg, pend_chip_next;
    logic [REG_INDEX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [BYTE_W-1:0]      pend_val_reg, pend_val_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic                   out_chip_reg, out_chip_next;
    logic [REG_INDEX_W-1:0] out_idx_reg, out_idx_next;
    logic [BYTE_W-1:0]      out_val_reg, out_val_next;
    logic                   out_last_reg, out_last_next;

    // Current-channel views
    logic [3:0]        ch_ext;
    logic [BYTE_W-1:0] cur_ptr, cur_val, tick_dec, step_dec, ptr_adv, step_sum, step_val;
    logic [ADDR_W-1:0] cur_base_delta, cur_base_ticks, cur_base_steps;
    logic              last_ch, out_free;

    assign ch_ext         = 4'(ch_reg);
    assign cur_ptr        = chan_ptr_reg[ch_reg];
    assign cur_val        = chan_val_reg[ch_reg];
    assign tick_dec       = chan_tick_reg[ch_reg] - COUNT_SEED;
    assign step_dec       = chan_step_reg[ch_reg] - COUNT_SEED;
    assign ptr_adv        = cur_ptr + 8'd2;
    assign cur_base_delta = entry_addr(cur_ptr, ENT_DELTA);
    assign cur_base_ticks = entry_addr(cur_ptr, ENT_TICKS);
    assign cur_base_steps = entry_addr(cur_ptr, ENT_STEPS);
    assign last_ch        = (ch_reg == '0);
    assign out_free       = !out_valid_reg || rsp.ready;

    // Odd channels keep their old high nibble on a step
    assign step_sum = cur_val + rd_data_reg;
    assign step_val = ch_reg[0] ? ((cur_val & HI_NIBBLE) | (step_sum & LO_NIBBLE)) : step_sum;

    assign req.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.chip_select    = out_chip_reg;
    assign rsp.register_index = out_idx_reg;
    assign rsp.register_value = out_val_reg;
    assign rsp.last_write     = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        row_next        = row_reg;
        fcnt_next       = fcnt_reg;
        chan_ptr_next   = chan_ptr_reg;
        chan_val_next   = chan_val_reg;
        chan_step_next  = chan_step_reg;
        chan_tick_next  = chan_tick_reg;
        pend_valid_next = pend_valid_reg;
        pend_chip_next  = pend_chip_reg;
        pend_idx_next   = pend_idx_reg;
        pend_val_next   = pend_val_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_chip_next   = out_chip_reg;
        out_idx_next    = out_idx_reg;
        out_val_next    = out_val_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        rd_addr         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req.req_type)
                        REQ_LOAD:
                        begin
                            mem_we = 1'b1;
                        end
                        REQ_TRIGGER:
                        begin
                            if (req.play_allowed)
                            begin
                                ch_next    = CH_W'(NUM_CHANNELS - 1);
                                row_next   = req.sound_code;
                                state_next = ST_TRIG_RD;
                            end
                        end
                        REQ_TICK:
                        begin
                            ch_next    = CH_W'(NUM_CHANNELS - 1);
                            state_next = ST_TICK_CHK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_TRIG_RD:
            begin
                rd_addr    = ADDR_W'(row_reg);
                state_next = ST_TRIG_WB;
            end

            ST_TRIG_WB:
            begin
                if (rd_data_reg != '0)
                begin
                    chan_ptr_next[ch_reg]  = rd_data_reg;
                    chan_tick_next[ch_reg] = COUNT_SEED;
                    chan_step_next[ch_reg] = COUNT_SEED;
                end
                if (last_ch)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ch_next    = ch_reg - 1'b1;
                    row_next   = row_reg - 1'b1;
                    state_next = ST_TRIG_RD;
                end
            end

            ST_TICK_CHK:
            begin
                if (cur_ptr == '0 || tick_dec != '0)
                begin
                    if (cur_ptr != '0)
                    begin
                        chan_tick_next[ch_reg] = tick_dec;
                    end
                    if (last_ch)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        ch_next = ch_reg - 1'b1;
                    end
                end
                else
                begin
                    chan_tick_next[ch_reg] = tick_dec;
                    chan_step_next[ch_reg] = step_dec;
                    if (step_dec != '0)
                    begin
                        // Step: fetch the delta now, the tick reload next
                        rd_addr    = cur_base_delta;
                        state_next = ST_STEP_DLT;
                    end
                    else
                    begin
                        fcnt_next  = '0;
                        state_next = ST_FETCH_A0;
                    end
                end
            end

            ST_STEP_DLT:
            begin
                chan_val_next[ch_reg] = step_val;
                rd_addr               = cur_base_ticks;
                state_next            = ST_STEP_TCK;
            end

            ST_STEP_TCK:
            begin
                chan_tick_next[ch_reg] = rd_data_reg;
                state_next             = ST_EMIT;
            end

            ST_FETCH_A0:
            begin
                // Advance to the next entry and read its value byte
                chan_ptr_next[ch_reg] = ptr_adv;
                rd_addr               = entry_addr(ptr_adv, ENT_VALUE);
                fcnt_next             = fcnt_reg + 1'b1;
                state_next            = ST_FETCH_VAL;
            end

            ST_FETCH_VAL:
            begin
                chan_val_next[ch_reg] = rd_data_reg;
                rd_addr               = cur_base_steps;
                state_next            = ST_FETCH_STP;
            end

            ST_FETCH_STP:
            begin
                chan_step_next[ch_reg] = rd_data_reg;
                rd_addr                = cur_base_ticks;
                state_next             = ST_FETCH_END;
            end

            ST_FETCH_END:
            begin
                chan_tick_next[ch_reg] = rd_data_reg;
                if (rd_data_reg != '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    // End of script: restart at the value byte unless it is zero
                    // or the fetch bound is used up
                    chan_ptr_next[ch_reg] = '0;
                    if (cur_val == '0 || fcnt_reg >= FCNT_W'(MAX_FETCH))
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        chan_ptr_next[ch_reg] = cur_val;
                        state_next            = ST_FETCH_A0;
                    end
                end
            end

            ST_EMIT:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_chip_next  = pend_chip_reg;
                        out_idx_next   = pend_idx_reg;
                        out_val_next   = pend_val_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_chip_next  = ch_ext[3];
                    pend_idx_next   = ch_ext[2:0];
                    pend_val_next   = cur_val;
                    if (last_ch)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        ch_next    = ch_reg - 1'b1;
                        state_next = ST_TICK_CHK;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_chip_next   = pend_chip_reg;
                    out_idx_next    = pend_idx_reg;
                    out_val_next    = pend_val_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Script memory: one write port for loads, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            script_mem[ADDR_W'(req.load_address)] <= req.load_data;
        end
        rd_data_reg <= script_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                chan_ptr_reg[i]  <= '0;
                chan_val_reg[i]  <= '0;
                chan_step_reg[i] <= '0;
                chan_tick_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            chan_ptr_reg   <= chan_ptr_next;
            chan_val_reg   <= chan_val_next;
            chan_step_reg  <= chan_step_next;
            chan_tick_reg  <= chan_tick_next;
        end
    end

    // Sequencer working registers and payload: no reset needed
    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        row_reg       <= row_next;
        fcnt_reg      <= fcnt_next;
        pend_chip_reg <= pend_chip_next;
        pend_idx_reg  <= pend_idx_next;
        pend_val_reg  <= pend_val_next;
        out_chip_reg  <= out_chip_next;
        out_idx_reg   <= out_idx_next;
        out_val_reg   <= out_val_next;
        out_last_reg  <= out_last_next;
    end

`ifndef NO_ASSERTIONS
    // The held word is always flushed before the block takes a new request
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held result word left over at idle");

    // A restart chain never runs past its bound
    a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH_END) |-> (fcnt_reg <= FCNT_W'(MAX_FETCH)))
        else $error("fetch count past bound");

    // An accepted tick request always leaves the sequencer busy in the cycle after
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.req_type == REQ_TICK) |=> !req.ready)
        else $error("tick request did not start the sequencer");

    // A map write-back always follows its read
    a_trig_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRIG_WB) |-> ($past(state_reg) == ST_TRIG_RD))
        else $error("trigger write-back without map read");
`endif

endmodule

### tb/sv/ssq_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the sound script sequencer bench: request and register-write
// types, a channel-script predictor and the queue of expected register writes.
// Depends on ssq_pkg.
package ssq_tb_pkg;
    import ssq_pkg::*;

    localparam int NUM_CH      = NUM_CHANNELS_DEF;
    localparam int MEM_DEPTH   = SCRIPT_DEPTH_DEF;
    localparam int FETCH_LIMIT = MAX_FETCH_DEF;

    // Request type the block has no use for; it must be swallowed
    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct {
        logic [REQ_TYPE_W-1:0]  kind;
        logic [CODE_W-1:0]      code;
        logic                   play;
        logic [LOAD_ADDR_W-1:0] addr;
        byte_t                  data;
    } sound_req_t;

    typedef struct {
        logic                   chip;
        logic [REG_INDEX_W-1:0] index;
        byte_t                  value;
        logic                   last;
    } reg_write_t;

    typedef struct {
        byte_t value;
        byte_t ticks;
        byte_t delta;
        byte_t steps;
    } script_entry_t;

    class reg_write_scoreboard;
        byte_t      script_mem [MEM_DEPTH];
        bit         mem_loaded [MEM_DEPTH];
        byte_t      pointer    [NUM_CH];
        byte_t      level      [NUM_CH];
        byte_t      steps_left [NUM_CH];
        byte_t      ticks_left [NUM_CH];
        reg_write_t pending_writes [$];
        int         errors;
        int         first_unloaded;
        bit         record;

        function new();
            foreach (script_mem[a])
            begin
                script_mem[a] = '0;
                mem_loaded[a] = 1'b0;
            end
            foreach (pointer[c])
            begin
                pointer[c]    = '0;
                level[c]      = '0;
                steps_left[c] = '0;
                ticks_left[c] = '0;
            end
            errors         = 0;
            first_unloaded = -1;
            record         = 1'b1;
        endfunction

        // Read one byte; remember the first address that was never loaded
        function byte_t mem_byte(int a);
            int i;
            i = a % MEM_DEPTH;
            if (!mem_loaded[i] && first_unloaded < 0)
                first_unloaded = i;
            return script_mem[i];
        endfunction

        // Touch all four bytes, since the block may read any of them
        function script_entry_t read_entry(byte_t p);
            script_entry_t e;
            int            base;
            base    = ENTRY_OFS + 2 * int'(p);
            e.value = mem_byte(base + int'(ENT_VALUE));
            e.ticks = mem_byte(base + int'(ENT_TICKS));
            e.delta = mem_byte(base + int'(ENT_DELTA));
            e.steps = mem_byte(base + int'(ENT_STEPS));
            return e;
        endfunction

        function void fetch_script(int ch);
            script_entry_t e;
            int            fetches;
            fetches = 0;
            while (1)
            begin
                pointer[ch]    = pointer[ch] + 8'd2;
                e              = read_entry(pointer[ch]);
                level[ch]      = e.value;
                steps_left[ch] = e.steps;
                ticks_left[ch] = e.ticks;
                fetches++;
                if (e.ticks != 0)
                    return;
                // zero tick count ends the script; a nonzero value restarts it within the fetch limit
                pointer[ch] = '0;
                if (e.value == 0 || fetches >= FETCH_LIMIT)
                    return;
                pointer[ch] = e.value;
            end
        endfunction

        // Apply one accepted request to the model and queue the writes it causes
        function void note_request(sound_req_t r);
            byte_t         row;
            byte_t         p;
            byte_t         v;
            script_entry_t e;
            reg_write_t    w;
            bit            have_w;
            have_w = 1'b0;
            case (r.kind)
                REQ_LOAD:
                begin
                    script_mem[r.addr] = r.data;
                    mem_loaded[r.addr] = 1'b1;
                end
                REQ_TRIGGER:
                begin
                    if (r.play)
                    begin
                        row = r.code;
                        for (int ch = NUM_CH - 1; ch >= 0; ch--)
                        begin
                            p = mem_byte(int'(row));
                            if (p != 0)
                            begin
                                pointer[ch]    = p;
                                ticks_left[ch] = COUNT_SEED;
                                steps_left[ch] = COUNT_SEED;
                            end
                            row = row - 8'd1;
                        end
                    end
                end
                REQ_TICK:
                begin
                    for (int ch = NUM_CH - 1; ch >= 0; ch--)
                    begin
                        if (pointer[ch] == 0)
                            continue;
                        ticks_left[ch] = ticks_left[ch] - 8'd1;
                        if (ticks_left[ch] != 0)
                            continue;
                        steps_left[ch] = steps_left[ch] - 8'd1;
                        if (steps_left[ch] != 0)
                        begin
                            e = read_entry(pointer[ch]);
                            v = level[ch] + e.delta;
                            if (ch % 2 == 1)
                                v = (level[ch] & HI_NIBBLE) | (v & LO_NIBBLE);
                            level[ch]      = v;
                            ticks_left[ch] = e.ticks;
                        end
                        else
                            fetch_script(ch);
                        if (have_w && record)
                            pending_writes.push_back(w);
                        w.chip  = (ch >= NUM_CH / 2);
                        w.index = ch[REG_INDEX_W-1:0];
                        w.value = level[ch];
                        w.last  = 1'b0;
                        have_w  = 1'b1;
                    end
                end
                default: ;
            endcase
            if (have_w && record)
            begin
                w.last = 1'b1;
                pending_writes.push_back(w);
            end
        endfunction

        // Dry run: first never-loaded address the request would read, or -1
        function int first_unloaded_read(sound_req_t r);
            byte_t saved_ptr   [NUM_CH];
            byte_t saved_level [NUM_CH];
            byte_t saved_steps [NUM_CH];
            byte_t saved_ticks [NUM_CH];
            if (r.kind == REQ_LOAD)
                return -1;
            saved_ptr      = pointer;
            saved_level    = level;
            saved_steps    = steps_left;
            saved_ticks    = ticks_left;
            record         = 1'b0;
            first_unloaded = -1;
            note_request(r);
            pointer    = saved_ptr;
            level      = saved_level;
            steps_left = saved_steps;
            ticks_left = saved_ticks;
            record     = 1'b1;
            return first_unloaded;
        endfunction

        function void compare_field(string name, logic [7:0] expv, logic [7:0] gotv);
            if (gotv !== expv)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, expv, gotv);
                errors++;
            end
        endfunction

        function void check_write(reg_write_t got);
            reg_write_t e;
            if (pending_writes.size() == 0)
            begin
                $error("unexpected write: chip_select %0d register_index %0d value 0x%0h",
                       got.chip, got.index, got.value);
                errors++;
                return;
            end
            e = pending_writes.pop_front();
            compare_field("chip_select", 8'(e.chip), 8'(got.chip));
            compare_field("register_index", 8'(e.index), 8'(got.index));
            compare_field("register_value", e.value, got.value);
            compare_field("last_write", 8'(e.last), 8'(got.last));
        endfunction

        function int outstanding();
            return pending_writes.size();
        endfunction
    endclass

endpackage

### tb/sv/tb_sound_script_sequencer.sv
`timescale 1ns / 1ps
// Top of the sound script sequencer bench: clock, reset, request driver, register
// write sink with random stalls, watchdog and verdict.
// Depends on ssq_pkg, ssq_in_if, ssq_out_if, ssq_tb_pkg and sound_script_sequencer.
module tb_sound_script_sequencer;
    import ssq_pkg::*;
    import ssq_tb_pkg::*;

    localparam int CLK_HALF       = 2;     // ns, 4 ns period
    localparam int RESET_CYCLES   = 11;
    localparam int MAX_WAIT       = 16;    // longest random gap or stall per word
    localparam int RANDOM_ITEMS   = 150;
    localparam int LONG_HOLD      = 400;   // one long sink stall to back up the block
    localparam int DRAIN_CYCLES   = 600;   // a full tick with every channel chaining fetches
    localparam int WATCHDOG_LIMIT = 20000; // cycles without any accepted word

    logic clk;
    logic rst_n;

    ssq_in_if  req_if ();
    ssq_out_if rsp_if ();

    sound_script_sequencer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    reg_write_scoreboard board;
    bit no_idle;      // both sides skip their random waits while set
    bit hold_rsp;     // ask the sink for one long stall on its next word
    int quiet_cycles;

    always #CLK_HALF clk = ~clk;

    // Watchdog: end the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Register write sink: draw a stall per word, then hold ready until the
    // word is taken and check it against the oldest expected write.
    initial
    begin : write_sink
        int         stall;
        reg_write_t got;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                stall    = LONG_HOLD;
                hold_rsp = 1'b0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            // Only one assignment to ready per step: drop it now, raise it later
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
            got.chip  = rsp_if.chip_select;
            got.index = rsp_if.register_index;
            got.value = rsp_if.register_value;
            got.last  = rsp_if.last_write;
            board.check_write(got);
        end
    end

    // Byte address of one field of the script entry at pointer p
    function automatic int entry_byte_addr(byte_t p, logic [1:0] field);
        return ENTRY_OFS + 2 * int'(p) + int'(field);
    endfunction

    // Content for a byte that a request is about to read before anyone loaded it.
    // Map bytes are often zero so that triggers leave some channels alone;
    // tick/step bytes stay small so scripts move, with an occasional zero (end
    // or restart) and an occasional wide value.
    function automatic byte_t fill_byte(int a);
        byte_t b;
        int    rel;
        if (a < ENTRY_OFS)
        begin
            b = ($urandom_range(0, 9) < 4) ? 8'h00 : byte_t'($urandom_range(1, 255));
            return b;
        end
        rel = a - ENTRY_OFS;
        if (rel % 2 == 0)
            return byte_t'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0:       b = 8'h00;
            1:       b = byte_t'($urandom_range(0, 255));
            2, 3:    b = byte_t'($urandom_range(4, 8));
            default: b = byte_t'($urandom_range(1, 3));
        endcase
        return b;
    endfunction

    // Random content in every field; callers override what the request type uses
    function automatic sound_req_t random_fields(logic [REQ_TYPE_W-1:0] kind);
        sound_req_t r;
        r.kind = kind;
        r.code = CODE_W'($urandom_range(0, 255));
        r.play = 1'b1;
        r.addr = LOAD_ADDR_W'($urandom_range(0, MEM_DEPTH - 1));
        r.data = byte_t'($urandom_range(0, 255));
        return r;
    endfunction

    // Drive one request word: optional gap, then hold valid until accepted.
    // Returns at the accepting edge; the next call or release_request moves valid.
    task automatic send_request(sound_req_t r);
        int gap;
        @(negedge clk);
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= r.kind;
        req_if.sound_code   <= r.code;
        req_if.play_allowed <= r.play;
        req_if.load_address <= r.addr;
        req_if.load_data    <= r.data;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        board.note_request(r);
    endtask

    task automatic release_request();
        @(negedge clk);
        req_if.valid <= 1'b0;
    endtask

    task automatic load_byte(int a, byte_t d);
        sound_req_t r;
        r      = random_fields(REQ_LOAD);
        r.addr = LOAD_ADDR_W'(a);
        r.data = d;
        send_request(r);
    endtask

    // Load every byte the request would read that was never loaded, then send it
    task automatic issue(sound_req_t r);
        int a;
        a = board.first_unloaded_read(r);
        while (a >= 0)
        begin
            load_byte(a, fill_byte(a));
            a = board.first_unloaded_read(r);
        end
        send_request(r);
    endtask

    task automatic trigger(byte_t code, logic play);
        sound_req_t r;
        r      = random_fields(REQ_TRIGGER);
        r.code = code;
        r.play = play;
        issue(r);
    endtask

    task automatic tick();
        issue(random_fields(REQ_TICK));
    endtask

    // Stop offering requests until every expected write has come out
    task automatic drain();
        release_request();
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int pick;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_TICK;
        req_if.sound_code   = '0;
        req_if.play_allowed = 1'b0;
        req_if.load_address = '0;
        req_if.load_data    = '0;
        no_idle             = 1'b0;
        hold_rsp            = 1'b0;
        board               = new();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part ----
        // Extremes of address and data
        load_byte(MEM_DEPTH - 1, 8'hFF);
        load_byte(0, 8'h00);
        // Code 5 gives channel 15 pointer 0x3E; entry 0x40 restarts at 0x3E
        // forever, so the fetch bound must park the channel
        load_byte(5, 8'h3E);
        load_byte(entry_byte_addr(8'h40, ENT_VALUE), 8'h3E);
        load_byte(entry_byte_addr(8'h40, ENT_TICKS), 8'h00);
        // Pointer 0x10 leads to entry 0x12: zero ticks and zero value, plain end
        load_byte(6, 8'h10);
        load_byte(entry_byte_addr(8'h12, ENT_VALUE), 8'h00);
        load_byte(entry_byte_addr(8'h12, ENT_TICKS), 8'h00);
        // Pointer 0x20 leads to entry 0x22, which restarts at 0x50 into a live entry
        load_byte(7, 8'h20);
        load_byte(entry_byte_addr(8'h22, ENT_VALUE), 8'h50);
        load_byte(entry_byte_addr(8'h22, ENT_TICKS), 8'h00);
        load_byte(entry_byte_addr(8'h52, ENT_TICKS), 8'h02);
        // Pointer 0x60 leads to entry 0x62 with a zero step count (wraps to 255)
        load_byte(8, 8'h60);
        load_byte(entry_byte_addr(8'h62, ENT_TICKS), 8'h01);
        load_byte(entry_byte_addr(8'h62, ENT_STEPS), 8'h00);

        trigger(8'd5, 1'b0);                 // sounds not allowed: drop it
        issue(random_fields(REQ_UNUSED));    // unknown type: drop it
        trigger(8'd5, 1'b1);
        tick();                              // restart chain hits the bound
        trigger(8'd7, 1'b1);
        tick();
        tick();
        trigger(8'd8, 1'b1);
        tick();
        tick();
        // Zero the tick byte of the running entry: the next reload gives 0,
        // and the following decrement wraps
        load_byte(entry_byte_addr(8'h62, ENT_TICKS), 8'h00);
        tick();
        tick();
        trigger(8'd0, 1'b1);                 // map row wraps below address 0
        trigger(8'd255, 1'b1);
        tick();

        // ---- back-pressure: long sink stall while ticks keep coming ----
        no_idle  = 1'b1;
        hold_rsp = 1'b1;
        repeat (12) tick();
        no_idle = 1'b0;
        drain();

        // ---- random part: mostly ticks and triggers, some noise ----
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i % 50) >= 40;
            pick    = $urandom_range(0, 99);
            if (pick < 55)
                tick();
            else if (pick < 75)
                trigger(byte_t'($urandom_range(0, 255)), 1'b1);
            else if (pick < 80)
                trigger(byte_t'($urandom_range(0, 255)), 1'b0);
            else if (pick < 85)
                issue(random_fields(REQ_UNUSED));
            else
                load_byte(int'($urandom_range(0, MEM_DEPTH - 1)),
                          byte_t'($urandom_range(0, 255)));
        end
        no_idle = 1'b0;

        // ---- wind down: wait out stray writes, then judge ----
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sound_script_sequencer.f
src/ssq_pkg.sv
src/ssq_in_if.sv
src/ssq_out_if.sv
src/sound_script_sequencer.sv
tb/sv/ssq_tb_pkg.sv
tb/sv/tb_sound_script_sequencer.sv
